// ===== rtl/cpmd_pkg.sv =====
// ----------------------------------------------------------------------------
// cpmd_pkg: shared constants for the contiguous partition block
// Widths and default sizes used by the interfaces, the divider and the core.
// ----------------------------------------------------------------------------
package cpmd_pkg;

  localparam int unsigned MAX_CHAPTERS_DEF = 64;
  localparam int unsigned MAX_DAYS_DEF     = 16;
  localparam int unsigned PAGE_BITS        = 16;

  localparam int unsigned PAGE_W  = 16;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned DIDX_W  = 4;
  localparam int unsigned FIRST_W = 7;

endpackage
// ----------------------------------------------------------------------------

// ===== rtl/cpmd_if.sv =====
// ----------------------------------------------------------------------------
// cpmd channel interfaces
// Valid/ready channels for chapters, results and the day count register.
// ----------------------------------------------------------------------------
interface cpmd_in_if import cpmd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PAGE_W-1:0] page_count;
  logic              is_last;
  modport source (output valid, page_count, is_last, input ready);
  modport sink   (input valid, page_count, is_last, output ready);
endinterface

interface cpmd_out_if import cpmd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DIDX_W-1:0]  day_index;
  logic [FIRST_W-1:0] first_chapter;
  logic               no_solution;
  logic               last_result;
  modport source (output valid, day_index, first_chapter, no_solution, last_result,
                  input ready);
  modport sink   (input valid, day_index, first_chapter, no_solution, last_result,
                  output ready);
endinterface

interface cpmd_cfg_if import cpmd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DAY_W-1:0] day_count;
  modport source (output valid, day_count, input ready);
  modport sink   (input valid, day_count, output ready);
endinterface
// ----------------------------------------------------------------------------

// ===== rtl/cpmd_div.sv =====
// ----------------------------------------------------------------------------
// cpmd_div: restoring divider, one quotient bit per cycle
// Divides the page total by the day count.
// ----------------------------------------------------------------------------
module cpmd_div import cpmd_pkg::*; #(
  parameter int unsigned NUM_W = 22
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] dividend_i,
  input  logic [DAY_W-1:0] divisor_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_q;
  logic [DAY_W:0]   rem_q;
  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic [DAY_W:0]   rem_sh;
  logic             fits;

  assign rem_sh = {rem_q[DAY_W-1:0], quo_q[NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CNT_W'(NUM_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      rem_q <= fits ? rem_sh - {1'b0, divisor_i} : rem_sh;
      quo_q <= {quo_q[NUM_W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
// ----------------------------------------------------------------------------

// ===== rtl/contiguous_partition_min_deviation.sv =====
// ----------------------------------------------------------------------------
// contiguous_partition_min_deviation: linear partition by dynamic programming
// Splits a list of chapters into day_count contiguous groups of least deviation.
// ----------------------------------------------------------------------------
// Usage:
//  - cfg_ch sets day_count (reset 1); write it only while the block is idle.
//  - in_ch takes one chapter per cycle (page_count, is_last); the prefix sum
//    is stored as each chapter lands. The transfer with is_last = 1 starts a
//    run and in_ch.ready stays low until the run's last result is taken.
//  - A run: first the average (bit-serial divider), then one shared cost
//    unit walks every (groups, start, split) candidate through S_J_RD,
//    S_J_GC and S_J_AC, after S_ROW_RD and S_ROW_LAT for each row. The
//    traceback costs one more row search per day after the first.
//  - out_ch gives one result per day in order, day 0 first, with last_result
//    on the final one; an infeasible run gives a single no_solution result.
//  - A stalled out_ch simply holds the current result; nothing is lost.
//  - Reset empties the chapter list; no clearing pass is needed.
// ----------------------------------------------------------------------------
module contiguous_partition_min_deviation import cpmd_pkg::*; #(
  parameter int unsigned MAX_CHAPTERS = MAX_CHAPTERS_DEF,
  parameter int unsigned MAX_DAYS     = MAX_DAYS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cpmd_cfg_if.sink  cfg_ch,
  cpmd_in_if.sink   in_ch,
  cpmd_out_if.source out_ch
);

  localparam int unsigned CW     = $clog2(MAX_CHAPTERS + 1);
  localparam int unsigned KW     = $clog2(MAX_DAYS + 1);
  localparam int unsigned PS_W   = PAGE_BITS + $clog2(MAX_CHAPTERS) + 1;
  localparam int unsigned COST_W = PS_W + $clog2(MAX_DAYS) + 1;

  typedef enum logic [8:0] {
    S_LOAD    = 9'b000000001,
    S_NOSOL   = 9'b000000010,
    S_DIV     = 9'b000000100,
    S_ROW_RD  = 9'b000001000,
    S_ROW_LAT = 9'b000010000,
    S_J_RD    = 9'b000100000,
    S_J_GC    = 9'b001000000,
    S_J_AC    = 9'b010000000,
    S_EMIT    = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // storage: prefix sums (entry 0 reads as zero) and cost-to-go table
  logic [PS_W-1:0]   ps_mem  [MAX_CHAPTERS+1];
  logic [COST_W-1:0] ctg_mem [MAX_DAYS+1][MAX_CHAPTERS+1];
  logic [PS_W-1:0]   ps_rd_q;
  logic [COST_W-1:0] ctg_rd_q;
  logic [CW-1:0]     ps_addr;
  logic [KW-1:0]     ctg_k;
  logic [CW-1:0]     ctg_i;

  logic [DAY_W-1:0]  dcount_q, dcount_d;
  logic [CW-1:0]     cnt_q, cnt_d, n_q, n_d;
  logic              ovf_q, ovf_d;
  logic [PS_W-1:0]   ps_last_q, ps_last_d;
  logic [KW-1:0]     k_q, k_d;
  logic [CW-1:0]     i_q, i_d, j_q, j_d;
  logic              trace_q, trace_d, first_q, first_d;
  logic [PS_W-1:0]   psi_q, psi_d, avg_q, avg_d, g_q, g_d;
  logic [COST_W-1:0] best_q, best_d, target_q, target_d;

  // load path
  logic              in_xfer, full;
  logic [PS_W-1:0]   page_ext, sum_new, tot_new;
  logic [CW-1:0]     n_new;
  logic              ovf_new, bad_run;

  // shared cost unit
  logic [PS_W-1:0]   seg, dev;
  logic [COST_W-1:0] cand, best_new;
  logic              last_j, ctg_we;

  logic              div_start, div_done;
  logic [PS_W-1:0]   div_quo;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign full     = 32'(cnt_q) >= MAX_CHAPTERS;
  assign page_ext = PS_W'(in_ch.page_count[PAGE_BITS-1:0]);
  assign sum_new  = ps_last_q + page_ext;
  assign tot_new  = full ? ps_last_q : sum_new;
  assign n_new    = full ? cnt_q : cnt_q + 1'b1;
  assign ovf_new  = ovf_q || full;
  assign bad_run  = ovf_new || (dcount_q == '0) || (32'(dcount_q) > MAX_DAYS)
                 || (32'(dcount_q) > 32'(n_new));

  assign div_start = (state_q == S_LOAD) && in_xfer && in_ch.is_last && !bad_run;

  cpmd_div #(.NUM_W(PS_W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (tot_new),
    .divisor_i  (dcount_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // group cost |avg - (ps[j] - ps[i])| registered, then added to cost-to-go
  assign seg      = ps_rd_q - psi_q;
  assign dev      = (seg > avg_q) ? seg - avg_q : avg_q - seg;
  assign cand     = COST_W'(g_q) + ((k_q == KW'(1)) ? '0 : ctg_rd_q);
  assign best_new = (first_q || cand < best_q) ? cand : best_q;
  assign last_j   = j_q == (n_q + 1'b1 - CW'(k_q));
  assign ctg_we   = (state_q == S_J_AC) && !trace_q && last_j;

  // read addresses; held through S_J_GC so the table word is still there
  // when the sum is formed
  always_comb begin
    ps_addr = '0;
    ctg_k   = k_q;
    ctg_i   = i_q;
    case (state_q)
      S_ROW_RD: ps_addr = i_q;
      S_J_RD, S_J_GC: begin
        ps_addr = j_q;
        ctg_k   = k_q - 1'b1;
        ctg_i   = j_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && !full) begin
      ps_mem[cnt_q + 1'b1] <= sum_new;
    end
    ps_rd_q  <= (ps_addr == '0) ? '0 : ps_mem[ps_addr];
    if (ctg_we) begin
      ctg_mem[k_q][i_q] <= best_new;
    end
    ctg_rd_q <= ctg_mem[ctg_k][ctg_i];
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    dcount_d  = dcount_q;
    cnt_d     = cnt_q;
    n_d       = n_q;
    ovf_d     = ovf_q;
    ps_last_d = ps_last_q;
    k_d       = k_q;
    i_d       = i_q;
    j_d       = j_q;
    trace_d   = trace_q;
    first_d   = first_q;
    psi_d     = psi_q;
    avg_d     = avg_q;
    g_d       = g_q;
    best_d    = best_q;
    target_d  = target_q;

    if (cfg_ch.valid) begin
      dcount_d = cfg_ch.day_count;
    end

    case (state_q)
      S_LOAD: begin
        if (in_xfer) begin
          if (in_ch.is_last) begin
            cnt_d     = '0;
            ovf_d     = 1'b0;
            ps_last_d = '0;
            n_d       = n_new;
            state_d   = bad_run ? S_NOSOL : S_DIV;
          end else begin
            cnt_d     = n_new;
            ovf_d     = ovf_new;
            ps_last_d = tot_new;
          end
        end
      end
      S_NOSOL: begin
        if (out_ch.ready) begin
          state_d = S_LOAD;
        end
      end
      S_DIV: begin
        if (div_done) begin
          avg_d   = div_quo;
          k_d     = KW'(1);
          i_d     = '0;
          trace_d = 1'b0;
          state_d = S_ROW_RD;
        end
      end
      S_ROW_RD: state_d = S_ROW_LAT;
      S_ROW_LAT: begin
        psi_d    = ps_rd_q;
        target_d = ctg_rd_q;
        j_d      = (k_q == KW'(1)) ? n_q : i_q + 1'b1;
        first_d  = 1'b1;
        state_d  = S_J_RD;
      end
      S_J_RD: state_d = S_J_GC;
      S_J_GC: begin
        g_d     = dev;
        state_d = S_J_AC;
      end
      S_J_AC: begin
        if (trace_q) begin
          if (cand == target_q) begin
            i_d     = j_q;
            k_d     = k_q - 1'b1;
            state_d = S_EMIT;
          end else begin
            j_d     = j_q + 1'b1;
            state_d = S_J_RD;
          end
        end else if (last_j) begin
          if (i_q == n_q - CW'(k_q)) begin
            i_d = '0;
            if (32'(k_q) == 32'(dcount_q)) begin
              state_d = S_EMIT;
            end else begin
              k_d     = k_q + 1'b1;
              state_d = S_ROW_RD;
            end
          end else begin
            i_d     = i_q + 1'b1;
            state_d = S_ROW_RD;
          end
        end else begin
          best_d  = best_new;
          first_d = 1'b0;
          j_d     = j_q + 1'b1;
          state_d = S_J_RD;
        end
      end
      S_EMIT: begin
        if (out_ch.ready) begin
          if (k_q == KW'(1)) begin
            state_d = S_LOAD;
          end else begin
            trace_d = 1'b1;
            state_d = S_ROW_RD;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_LOAD;
      dcount_q  <= DAY_W'(1);
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
      ps_last_q <= '0;
      trace_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      dcount_q  <= dcount_d;
      cnt_q     <= cnt_d;
      ovf_q     <= ovf_d;
      ps_last_q <= ps_last_d;
      trace_q   <= trace_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    k_q      <= k_d;
    i_q      <= i_d;
    j_q      <= j_d;
    first_q  <= first_d;
    psi_q    <= psi_d;
    avg_q    <= avg_d;
    g_q      <= g_d;
    best_q   <= best_d;
    target_q <= target_d;
  end

  // ports
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = state_q == S_LOAD;

  // in S_EMIT, k_q is the number of days still to emit and i_q the start
  assign out_ch.valid         = (state_q == S_EMIT) || (state_q == S_NOSOL);
  assign out_ch.no_solution   = state_q == S_NOSOL;
  assign out_ch.day_index     = (state_q == S_EMIT) ? DIDX_W'(32'(dcount_q) - 32'(k_q)) : '0;
  assign out_ch.first_chapter = (state_q == S_EMIT) ? FIRST_W'(32'(i_q) + 1) : '0;
  assign out_ch.last_result   = (state_q == S_NOSOL) || (k_q == KW'(1));

endmodule
// ----------------------------------------------------------------------------

// ===== rtl/cpmd_chk.sv =====
// ----------------------------------------------------------------------------
// cpmd_chk: port-level checks for the partition block
// Watches the channel handshakes and result fields over time.
// ----------------------------------------------------------------------------
module cpmd_chk import cpmd_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [DIDX_W-1:0]  out_day_index,
  input logic [FIRST_W-1:0] out_first_chapter,
  input logic               out_no_solution,
  input logic               out_last_result
);

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready && out_valid))
    else $error("chapter intake open while a result is pending");

  a_nosol_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_no_solution |-> out_last_result && out_day_index == '0
      && out_first_chapter == '0)
    else $error("malformed no-solution result");

  a_first_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_no_solution |-> out_first_chapter != '0)
    else $error("day result without a first chapter");

  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && out_last_result |=> !out_valid && in_ready)
    else $error("block not idle after the final result");

endmodule

bind contiguous_partition_min_deviation cpmd_chk u_cpmd_chk (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_day_index     (out_ch.day_index),
  .out_first_chapter (out_ch.first_chapter),
  .out_no_solution   (out_ch.no_solution),
  .out_last_result   (out_ch.last_result)
);
// ----------------------------------------------------------------------------
